// File: rtl/spsw_pkg.sv
// Shared constants for the segmented prime sieve window block.
// No dependencies; used by the remainder pipeline and the top level.
package spsw_pkg;

  // Width of the query range bounds and of the window index.
  localparam int FIELD_W = 30;
  localparam int IDX_W   = 10;

  // Width of the result mask, the largest window supported.
  localparam int MASK_W  = 64;
  localparam int MASK_IW = 6;

  // Window start: 30-bit bound plus up to 1023 windows of 128 values.
  localparam int START_W = 31;

endpackage

// File: rtl/segmented_prime_sieve_window_top.sv
// Top level of the segmented prime sieve window block.
// Depends on spsw_pkg, spsw_ram, spsw_table_build and spsw_rem_pipe.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | range_low, range_high, window_index
//  output  | out_valid / out_ready| prime_mask, two_in_range, last_window
//
// After reset the base prime table is built: a flag sweep over BASE_LIMIT/2 entries,
// then a read and check of each odd candidate and a strike of each struck multiple;
// in_ready stays low until it finishes.
// A window issues one base prime per cycle from the prime memory read port into
// the 31-stage remainder pipeline, and stalls for each further strike of a
// prime below WINDOW_ODDS.
module segmented_prime_sieve_window_top
  import spsw_pkg::*;
#(
  parameter int BASE_LIMIT  = 32768,
  parameter int WINDOW_ODDS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FIELD_W-1:0]  range_low,
  input  logic [FIELD_W-1:0]  range_high,
  input  logic [IDX_W-1:0]    window_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MASK_W-1:0]   prime_mask,
  output logic                two_in_range,
  output logic                last_window
);

  localparam int FAW = $clog2(BASE_LIMIT / 2);
  localparam int PW  = FAW + 1;
  localparam int DW  = PW + 2;
  localparam logic [START_W-1:0] STRIDE = START_W'(2 * WINDOW_ODDS);
  localparam logic [START_W:0]   TAIL   = (START_W+1)'(2 * (WINDOW_ODDS - 1));
  localparam logic [DW-1:0]      WIN    = DW'(WINDOW_ODDS);

  typedef enum logic [1:0] {
    S_IDLE, S_RUN, S_FLUSH
  } state_t;

  state_t              state;
  logic                accept;
  logic                adv;

  // Table builder and prime memory.
  logic                pw_we;
  logic [FAW-1:0]      pw_addr;
  logic [PW-1:0]       pw_data;
  logic [FAW:0]        prime_count;
  logic                table_done;
  logic [PW-1:0]       rd_p;

  // Window context.
  logic [START_W-1:0]  start;
  logic [START_W-1:0]  start_next;
  logic [FIELD_W-1:0]  hi;
  logic [MASK_W-1:0]   mask;
  logic [MASK_W-1:0]   mask_init;
  logic                two_flag;
  logic                last_flag;

  // Issue and pipeline stages.
  logic                issuing;
  logic [FAW-1:0]      t;
  logic                t_last;
  logic                rv;
  logic                rlast;
  logic                q_vld;
  logic                q_last;
  logic [PW-1:0]       q_p;
  logic [PW-1:0]       q_rem;
  logic                ov;
  logic                olast;
  logic                oen;
  logic [PW-1:0]       op;
  logic [PW:0]         ooff;
  logic                sv;
  logic                slast;
  logic                sen;
  logic [PW-1:0]       sp;
  logic [PW:0]         soff;
  logic [DW-1:0]       s_nextoff;
  logic                s_hit;
  logic                win_done;

  // Offset stage arithmetic.
  logic [DW-1:0]       three_p;
  logic [START_W-1:0]  three_p_w;
  logic [DW-1:0]       d_lo;
  logic [DW-1:0]       d_hi;
  logic [DW-1:0]       d_sel;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && table_done;

  spsw_table_build #(.BASE_LIMIT(BASE_LIMIT)) u_build (
    .clk         (clk),
    .rst         (rst),
    .pw_we       (pw_we),
    .pw_addr     (pw_addr),
    .pw_data     (pw_data),
    .prime_count (prime_count),
    .done        (table_done)
  );

  spsw_ram #(.WIDTH(PW), .DEPTH(BASE_LIMIT / 2)) u_primes (
    .clk   (clk),
    .we    (pw_we),
    .waddr (pw_addr),
    .wdata (pw_data),
    .re    (adv),
    .raddr (t),
    .rdata (rd_p)
  );

  // Window start and the in-range survivor mask at accept time.
  assign start_next = START_W'({1'b0, range_low | FIELD_W'(1)})
                    + START_W'(window_index) * STRIDE;

  always_comb begin
    logic [START_W:0] nval;
    for (int k = 0; k < MASK_W; k++) begin
      nval = {1'b0, start_next} + (START_W+1)'(2 * k);
      mask_init[k] = (k < WINDOW_ODDS) && (nval <= (START_W+1)'(range_high))
                   && (nval != (START_W+1)'(1));
    end
  end

  // The strike stage holds while a small prime has more multiples to clear.
  assign s_nextoff = DW'(soff) + DW'(sp);
  assign adv       = !(sv && sen && (s_nextoff < WIN));
  assign s_hit     = sv && sen && (DW'(soff) < WIN);
  assign win_done  = sv && slast && adv;
  assign t_last    = ({1'b0, t} + 1'b1) == prime_count;

  spsw_rem_pipe #(.PW(PW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (rv),
    .in_last  (rlast),
    .in_p     (rd_p),
    .start    (start),
    .out_vld  (q_vld),
    .out_last (q_last),
    .out_p    (q_p),
    .out_rem  (q_rem)
  );

  // First odd multiple at or above max(start, 3p), as an index offset.
  assign three_p   = DW'(q_p) + {q_p, 1'b0};
  assign three_p_w = START_W'(three_p);
  assign d_lo      = DW'(three_p_w - start);
  assign d_hi      = (q_rem == '0) ? '0 : DW'(q_p - q_rem);
  assign d_sel     = (start <= three_p_w) ? d_lo
                   : (d_hi[0] ? d_hi + DW'(q_p) : d_hi);

  // Control state, issue counter and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      rv        <= 1'b0;
      ov        <= 1'b0;
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FLUSH)) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        rv  <= issuing;
        ov  <= q_vld;
        sv  <= ov;
        if (issuing) begin
          t <= t + 1'b1;
          if (t_last) begin
            issuing <= 1'b0;
          end
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            issuing <= 1'b1;
            t       <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (win_done) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            prime_mask   <= mask;
            two_in_range <= two_flag;
            last_window  <= last_flag;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the window and the pipeline stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      start     <= start_next;
      hi        <= range_high;
      mask      <= mask_init;
      two_flag  <= (window_index == '0) && (range_low <= FIELD_W'(2))
                && (range_high >= FIELD_W'(2));
      last_flag <= ({1'b0, start_next} + TAIL) >= (START_W+1)'(range_high);
    end else if (s_hit) begin
      mask[soff[MASK_IW-1:0]] <= 1'b0;
    end
    if (adv) begin
      rlast <= issuing && t_last;
      olast <= q_last;
      op    <= q_p;
      oen   <= (FIELD_W'(three_p) <= hi);
      ooff  <= d_sel[DW-1:1];
      slast <= olast;
      sen   <= oen;
      sp    <= op;
      soff  <= ooff;
    end else begin
      soff  <= s_nextoff[PW:0];
    end
  end

  // The pipeline is empty whenever the block is ready for a new window.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!issuing && !sv && !ov && !rv))
    else $error("sieve pipeline not empty while idle");

  // Windows are only taken once the prime table is complete.
  a_table_first: assert property (@(posedge clk) disable iff (rst)
    accept |-> table_done)
    else $error("window accepted before table build finished");

  // A stall only comes from a prime that still has strikes in the window.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !adv |-> (sv && sen && (state == S_RUN)))
    else $error("pipeline stalled without a pending strike");

  // A finished window reaches the output once the register is free.
  a_flush_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FLUSH) && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished window not delivered");

endmodule

// File: rtl/spsw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module spsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the entry written in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/spsw_table_build.sv
// Builds the base prime table after reset with a flag-memory sieve.
// Depends on spsw_ram for the odd-number flag store.
module spsw_table_build #(
  parameter int BASE_LIMIT = 32768
) (
  input  logic                                 clk,
  input  logic                                 rst,
  output logic                                 pw_we,
  output logic [$clog2(BASE_LIMIT/2)-1:0]      pw_addr,
  output logic [$clog2(BASE_LIMIT/2):0]        pw_data,
  output logic [$clog2(BASE_LIMIT/2):0]        prime_count,
  output logic                                 done
);

  localparam int FD  = BASE_LIMIT / 2;
  localparam int FAW = $clog2(FD);
  localparam int NW  = FAW + 1;
  localparam int MW  = NW + 2;
  localparam logic [FAW-1:0] LAST_IDX = FAW'(FD - 1);
  localparam logic [2*NW-1:0] LIM_SQ = (2*NW)'(BASE_LIMIT);
  localparam logic [MW-1:0]   LIM_M  = MW'(BASE_LIMIT);

  typedef enum logic [2:0] {
    S_CLR, S_RD, S_CHK, S_STRK, S_FIN
  } state_t;

  state_t           state;
  logic [FAW-1:0]   idx;
  logic [NW-1:0]    n;
  logic [2*NW-1:0]  sq;
  logic [MW-1:0]    m;
  logic [MW-1:0]    m_next;
  logic [FAW:0]     count;
  logic             flag;
  logic             fw_we;
  logic [FAW-1:0]   fw_addr;
  logic             fw_data;

  assign n      = {idx, 1'b1};
  assign m_next = m + {1'b0, n, 1'b0};

  // Flag store: cleared by a sweep, then set at struck odd multiples.
  always_comb begin
    fw_we   = 1'b0;
    fw_addr = idx;
    fw_data = 1'b0;
    case (state)
      S_CLR: begin
        fw_we = 1'b1;
      end
      S_STRK: begin
        fw_we   = 1'b1;
        fw_addr = m[FAW:1];
        fw_data = 1'b1;
      end
      default: begin
        fw_we = 1'b0;
      end
    endcase
  end

  spsw_ram #(.WIDTH(1), .DEPTH(FD)) u_flags (
    .clk   (clk),
    .we    (fw_we),
    .waddr (fw_addr),
    .wdata (fw_data),
    .re    (1'b1),
    .raddr (idx),
    .rdata (flag)
  );

  // A surviving odd number is a prime: append it to the table.
  assign pw_we       = (state == S_CHK) && !flag;
  assign pw_addr     = count[FAW-1:0];
  assign pw_data     = n;
  assign prime_count = count;
  assign done        = (state == S_FIN);

  // Sieve sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx   <= '0;
      count <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (idx == LAST_IDX) begin
            idx   <= FAW'(1);
            state <= S_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RD: begin
          sq    <= n * n;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!flag) begin
            count <= count + 1'b1;
          end
          if (!flag && (sq < LIM_SQ)) begin
            m     <= sq[MW-1:0];
            state <= S_STRK;
          end else if (idx == LAST_IDX) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_STRK: begin
          m <= m_next;
          if (m_next >= LIM_M) begin
            if (idx == LAST_IDX) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          state <= S_FIN;
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

endmodule

// File: rtl/spsw_rem_pipe.sv
// Pipelined restoring remainder: window start modulo one base prime per cycle while adv is high.
// Depends on spsw_pkg for the start width.
module spsw_rem_pipe
  import spsw_pkg::*;
#(
  parameter int PW = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  logic               in_last,
  input  logic [PW-1:0]      in_p,
  input  logic [START_W-1:0] start,
  output logic               out_vld,
  output logic               out_last,
  output logic [PW-1:0]      out_p,
  output logic [PW-1:0]      out_rem
);

  logic [PW-1:0] st_p   [START_W];
  logic [PW-1:0] st_rem [START_W];
  logic          st_vld [START_W];
  logic          st_last[START_W];

  // One dividend bit per stage, most significant first.
  for (genvar i = 0; i < START_W; i++) begin : g_stage
    logic [PW-1:0] p_in;
    logic [PW-1:0] rem_in;
    logic          vld_in;
    logic          last_in;
    logic [PW:0]   shifted;
    logic [PW:0]   diff;

    if (i == 0) begin : g_first
      assign p_in    = in_p;
      assign rem_in  = '0;
      assign vld_in  = in_vld;
      assign last_in = in_last;
    end else begin : g_rest
      assign p_in    = st_p[i-1];
      assign rem_in  = st_rem[i-1];
      assign vld_in  = st_vld[i-1];
      assign last_in = st_last[i-1];
    end

    assign shifted = {rem_in, start[START_W-1-i]};
    assign diff    = shifted - {1'b0, p_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[i]  <= 1'b0;
        st_last[i] <= 1'b0;
      end else if (adv) begin
        st_vld[i]  <= vld_in;
        st_last[i] <= last_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_p[i]   <= p_in;
        st_rem[i] <= (shifted >= {1'b0, p_in}) ? diff[PW-1:0] : shifted[PW-1:0];
      end
    end
  end

  assign out_vld  = st_vld[START_W-1];
  assign out_last = st_last[START_W-1];
  assign out_p    = st_p[START_W-1];
  assign out_rem  = st_rem[START_W-1];

endmodule
